// File: rtl/core/piecewise_linear_schedule_interp_defines.svh
// Assertion macros shared by the files that check their own logic.
// Each macro samples on the rising edge of aclk and is off while aresetn is low.
`ifndef PIECEWISE_LINEAR_SCHEDULE_INTERP_DEFINES_SVH
`define PIECEWISE_LINEAR_SCHEDULE_INTERP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLSI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/plsi_pkg.sv
package plsi_pkg;

    localparam int DATA_W     = 32;
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int ENTRY_W    = 4;
    localparam int CNT_W      = 5;
    localparam int MODE_W     = 3;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int STEP_W     = $clog2(DATA_W + 1);
    localparam int TDATA_W    = 136;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCHED = 3'd1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // Search token that travels down the row of breakpoint cells.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] prev_t;
        logic [DATA_W-1:0] prev_a;
        logic              lo_hit;
        logic [DATA_W-1:0] lo_a;
        logic              hi_hit;
        logic [DATA_W-1:0] hi_a;
        logic              seg_hit;
        logic [DATA_W-1:0] seg_t0;
        logic [DATA_W-1:0] seg_t1;
        logic [DATA_W-1:0] seg_a0;
        logic [DATA_W-1:0] seg_a1;
    } probe_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_res_t;

endpackage

// File: rtl/core/plsi_cell.sv
// One breakpoint slot. It stores a time and angle pair and passes the search
// token on to the next slot, marking the first segment that brackets the time.
module plsi_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [plsi_pkg::IDX_W-1:0]    cell_idx,
    input  logic [plsi_pkg::CNT_W-1:0]    point_count,
    input  logic                          wr_en,
    input  logic [plsi_pkg::DATA_W-1:0]   wr_time,
    input  logic [plsi_pkg::DATA_W-1:0]   wr_angle,
    input  plsi_pkg::probe_t              probe_in,
    output plsi_pkg::probe_t              probe_out
);

    logic [plsi_pkg::DATA_W-1:0] time_reg;
    logic [plsi_pkg::DATA_W-1:0] angle_reg;
    plsi_pkg::probe_t            probe_reg;
    plsi_pkg::probe_t            probe_next;
    logic                        in_use;
    logic                        is_last;
    logic                        brackets;

    assign in_use  = 32'(cell_idx) < 32'(point_count);
    assign is_last = (32'(cell_idx) + 32'd1) == 32'(point_count);
    assign brackets = ($signed(probe_in.prev_t) <= $signed(probe_in.t)) &&
                      ($signed(probe_in.t) <= $signed(time_reg));

    always_comb begin
        probe_next        = probe_in;
        probe_next.prev_t = time_reg;
        probe_next.prev_a = angle_reg;
        if (cell_idx == '0) begin
            probe_next.lo_hit = $signed(probe_in.t) <= $signed(time_reg);
            probe_next.lo_a   = angle_reg;
        end
        if (in_use && (cell_idx != '0) && !probe_in.seg_hit && brackets) begin
            probe_next.seg_hit = 1'b1;
            probe_next.seg_t0  = probe_in.prev_t;
            probe_next.seg_t1  = time_reg;
            probe_next.seg_a0  = probe_in.prev_a;
            probe_next.seg_a1  = angle_reg;
        end
        if (is_last) begin
            probe_next.hi_hit = $signed(probe_in.t) >= $signed(time_reg);
            probe_next.hi_a   = angle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_reg  <= wr_time;
            angle_reg <= wr_angle;
        end
    end

    // Only the valid bit is reset; the payload follows it unconditionally.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.t       <= probe_next.t;
        probe_reg.prev_t  <= probe_next.prev_t;
        probe_reg.prev_a  <= probe_next.prev_a;
        probe_reg.lo_hit  <= probe_next.lo_hit;
        probe_reg.lo_a    <= probe_next.lo_a;
        probe_reg.hi_hit  <= probe_next.hi_hit;
        probe_reg.hi_a    <= probe_next.hi_a;
        probe_reg.seg_hit <= probe_next.seg_hit;
        probe_reg.seg_t0  <= probe_next.seg_t0;
        probe_reg.seg_t1  <= probe_next.seg_t1;
        probe_reg.seg_a0  <= probe_next.seg_a0;
        probe_reg.seg_a1  <= probe_next.seg_a1;
    end

    assign probe_out = probe_reg;

endmodule

// File: rtl/core/plsi_div.sv
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in DATA_W bits.
module plsi_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [plsi_pkg::PROD_W-1:0]   dividend,
    input  logic [plsi_pkg::DATA_W-1:0]   divisor,
    output plsi_pkg::div_res_t            res
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [plsi_pkg::STEP_W-1:0] cnt_reg;
    logic [plsi_pkg::DATA_W-1:0] rem_reg;
    logic [plsi_pkg::DATA_W-1:0] quo_reg;
    logic [plsi_pkg::DATA_W:0]   shifted;
    logic [plsi_pkg::DATA_W:0]   diff;
    logic                        fits;

    assign shifted = {rem_reg, quo_reg[plsi_pkg::DATA_W-1]};
    assign fits    = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= plsi_pkg::STEP_W'(plsi_pkg::DATA_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == plsi_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[plsi_pkg::PROD_W-1:plsi_pkg::DATA_W];
            quo_reg <= dividend[plsi_pkg::DATA_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[plsi_pkg::DATA_W-1:0] : shifted[plsi_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[plsi_pkg::DATA_W-2:0], fits};
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

// File: rtl/core/piecewise_linear_schedule_interp.sv
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tuser: kind; tdata: entry_index, entry_time, entry_angle,
//                      sim_time, current_angle, 4 zero bits
// m_axis    out        tdata: angle_command
// apb       config     0x0 guidance_mode, 0x4 point_count
//
// A load writes its breakpoint cell. For an evaluate in pass-through mode or
// a mode that gives zero, the result goes through the push state into the
// output register. A schedule evaluate walks the row of 16 breakpoint cells,
// one cell per cycle: a clamped result then goes to the push state, a
// zero-length segment first through the multiply state, and an interpolated
// one through the multiply state, the divider start and the 32-step divider.
// One item is in work at a time. Reset (aresetn low, synchronous) clears the
// configuration registers and control state, not the breakpoint table. A
// stalled result waits in the output register while the next item is taken.
`include "piecewise_linear_schedule_interp_defines.svh"

module piecewise_linear_schedule_interp (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [plsi_pkg::TDATA_W-1:0]   s_tdata,  // entry_index[3:0], entry_time[35:4],
                                                     // entry_angle[67:36], sim_time[99:68],
                                                     // current_angle[131:100], zeros
    input  logic                           s_tuser,  // kind[0]
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [plsi_pkg::DATA_W-1:0]    m_tdata,  // angle_command[31:0]
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    localparam int DW = plsi_pkg::DATA_W;
    localparam int NP = plsi_pkg::MAX_POINTS;

    // Field slices of the input transfer.
    logic [plsi_pkg::ENTRY_W-1:0] s_entry_index;
    logic [DW-1:0]                s_entry_time;
    logic [DW-1:0]                s_entry_angle;
    logic [DW-1:0]                s_sim_time;
    logic [DW-1:0]                s_current_angle;

    assign s_entry_index   = s_tdata[3:0];
    assign s_entry_time    = s_tdata[35:4];
    assign s_entry_angle   = s_tdata[67:36];
    assign s_sim_time      = s_tdata[99:68];
    assign s_current_angle = s_tdata[131:100];

    // Configuration registers.
    logic [plsi_pkg::MODE_W-1:0] mode_reg;
    logic [plsi_pkg::CNT_W-1:0]  count_reg;
    logic [plsi_pkg::CNT_W-1:0]  count_next;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // A count whose low five bits exceed the table depth saturates at the depth.
    assign count_next = (32'(pwdata[plsi_pkg::CNT_W-1:0]) > 32'(NP))
                      ? plsi_pkg::CNT_W'(NP) : pwdata[plsi_pkg::CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                plsi_pkg::REG_MODE:  mode_reg  <= pwdata[plsi_pkg::MODE_W-1:0];
                plsi_pkg::REG_COUNT: count_reg <= count_next;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            plsi_pkg::REG_MODE:  prdata = 32'(mode_reg);
            plsi_pkg::REG_COUNT: prdata = 32'(count_reg);
            default:             prdata = '0;
        endcase
    end

    // Control state and transfers.
    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       s_xfer;
    logic       load_xfer;
    logic       eval_xfer;
    logic       sched_go;

    assign s_tready  = state_reg == ST_IDLE;
    assign s_xfer    = s_tvalid && s_tready;
    assign load_xfer = s_xfer && (s_tuser == plsi_pkg::KIND_LOAD);
    assign eval_xfer = s_xfer && (s_tuser == plsi_pkg::KIND_EVAL);
    assign sched_go  = eval_xfer && (mode_reg == plsi_pkg::MODE_SCHED) && (count_reg != '0);

    // Row of breakpoint cells. The search token enters cell 0 with the transfer
    // and passes through the register of each cell in turn to leave the last cell.
    plsi_pkg::probe_t chain [0:NP];
    plsi_pkg::probe_t chain_out;

    always_comb begin
        chain[0]       = '0;
        chain[0].valid = sched_go;
        chain[0].t     = s_sim_time;
    end

    for (genvar g = 0; g < NP; g++) begin : g_cell
        logic wr_en;
        assign wr_en = load_xfer && (32'(s_entry_index) == 32'(g));

        plsi_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (plsi_pkg::IDX_W'(g)),
            .point_count (count_reg),
            .wr_en       (wr_en),
            .wr_time     (s_entry_time),
            .wr_angle    (s_entry_angle),
            .probe_in    (chain[g]),
            .probe_out   (chain[g+1])
        );
    end

    assign chain_out = chain[NP];

    // Segment arithmetic. The bracketing test guarantees t0 <= t <= t1, so the
    // time differences are unsigned and fit in DW bits.
    logic [DW-1:0]            dt_reg;
    logic [DW-1:0]            dx_reg;
    logic [DW-1:0]            mag_reg;
    logic                     neg_reg;
    logic [DW-1:0]            a0_reg;
    logic [plsi_pkg::PROD_W-1:0] prod_reg;
    logic                     div_start_reg;
    logic [DW-1:0]            res_reg;
    logic                     seg_neg;
    plsi_pkg::div_res_t       div_res;

    assign seg_neg = $signed(chain_out.seg_a1) < $signed(chain_out.seg_a0);

    plsi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (dt_reg),
        .res      (div_res)
    );

    // Output register.
    logic          m_tvalid_reg;
    logic [DW-1:0] m_tdata_reg;
    logic          out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sched_go) begin
                    state_next = ST_WALK;
                end else if (eval_xfer) begin
                    state_next = ST_PUSH;
                end
            end
            ST_WALK: begin
                if (chain_out.valid) begin
                    if (!chain_out.lo_hit && !chain_out.hi_hit && chain_out.seg_hit) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_MUL: begin
                state_next = (dt_reg == '0) ? ST_PUSH : ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == ST_MUL) && (dt_reg != '0);
            if (state_reg == ST_PUSH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                // Pass-through mode returns the current angle; a mode with no
                // schedule, or a schedule with no points, returns zero.
                res_reg <= (mode_reg == plsi_pkg::MODE_PASS) ? s_current_angle : '0;
            end
            ST_WALK: begin
                // Precedence: at or before the first point, at or after the last point,
                // first bracketing segment, and zero for an unordered table.
                if (chain_out.lo_hit) begin
                    res_reg <= chain_out.lo_a;
                end else if (chain_out.hi_hit) begin
                    res_reg <= chain_out.hi_a;
                end else begin
                    res_reg <= '0;
                end
                dt_reg  <= chain_out.seg_t1 - chain_out.seg_t0;
                dx_reg  <= chain_out.t - chain_out.seg_t0;
                neg_reg <= seg_neg;
                mag_reg <= seg_neg ? (chain_out.seg_a0 - chain_out.seg_a1)
                                   : (chain_out.seg_a1 - chain_out.seg_a0);
                a0_reg  <= chain_out.seg_a0;
            end
            ST_MUL: begin
                // A zero-length segment returns its start angle.
                res_reg  <= a0_reg;
                prod_reg <= plsi_pkg::PROD_W'(mag_reg) * plsi_pkg::PROD_W'(dx_reg);
            end
            ST_DIV: begin
                if (div_res.done) begin
                    res_reg <= neg_reg ? (a0_reg - div_res.quotient)
                                       : (a0_reg + div_res.quotient);
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_tdata_reg <= res_reg;
                end
            end
            default: ;
        endcase
    end

    // The divider only finishes while the sequencer waits for it.
    `PLSI_ASSERT_SAME(a_div_done_in_div, div_res.done, state_reg == ST_DIV,
                      "divider finished outside the divide state")
    // The search token only leaves the cell row while the sequencer waits for it.
    `PLSI_ASSERT_SAME(a_walk_out_in_walk, chain_out.valid, state_reg == ST_WALK,
                      "search token left the cell row outside the walk state")
    // An evaluate transfer always starts work that holds off the next item.
    `PLSI_ASSERT_NEXT(a_eval_leaves_idle, eval_xfer, state_reg != ST_IDLE,
                      "evaluate transfer did not leave idle")
    // A finished result moves into a free output register and frees the block.
    `PLSI_ASSERT_NEXT(a_push_delivers, (state_reg == ST_PUSH) && out_free,
                      m_tvalid && (state_reg == ST_IDLE),
                      "result not moved into the output register")

endmodule
